// ===== src/sau_pkg.sv =====
package sau_pkg;

    localparam int WORD_W          = 32;
    localparam int FUNC_W          = 3;
    localparam int STATUS_W        = 2;
    localparam int DEPTH_OUT_W     = 7;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int OPERANDS_NEEDED = 2;

    // Operation codes carried on the func input.
    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SUB  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DIV  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_MOD  = 3'd4;

    // Status codes reported with every result.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

endpackage

// ===== src/stack_arithmetic_unit_top.sv =====
// Stack arithmetic unit: a bounded stack of signed 32-bit words with a binary
// arithmetic unit (push, sub, div, mul, mod).
// Command channel: a word (i_func, i_push_value) is taken at a rising edge
// where start is high and busy is low. busy stays high while an operation is
// being worked on, and start is ignored during that time.
// Result channel: each command yields exactly one result word (o_status,
// o_top_value, o_stack_depth), shown for one cycle with o_valid high. The
// receiver cannot stall, so every result must be taken in that cycle.
// Push, error outcomes and unused codes answer in the cycle after
// acceptance and never raise busy, so they can be issued every cycle.
// Sub and mul read the second entry from the stack memory in S_READ and
// write the result back in S_WRITE; busy is high through both states.
// Div and mod run through the radix-2 divider in S_DIV, one quotient bit
// per cycle, before the write-back; busy stays high throughout.
// The top of the stack is mirrored in a register so that it never needs a
// memory read. Reset (i_rst_n low, synchronous) empties the stack; the stack
// memory itself is not cleared, since only written entries are ever read.
module stack_arithmetic_unit_top #(
    parameter int STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sau_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [sau_pkg::WORD_W-1:0]   i_push_value,
    output logic                                o_valid,
    output logic [sau_pkg::STATUS_W-1:0]        o_status,
    output logic signed [sau_pkg::WORD_W-1:0]   o_top_value,
    output logic [sau_pkg::DEPTH_OUT_W-1:0]     o_stack_depth
);

    localparam int W      = sau_pkg::WORD_W;
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int DCNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_WRITE
    } t_state;

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
        magnitude = v[W-1] ? (W'(0) - v) : v;
    endfunction

    t_state                        r_state;
    logic [DCNT_W-1:0]             r_depth;
    logic [W-1:0]                  r_top;
    logic [W-1:0]                  r_res;
    logic [sau_pkg::FUNC_W-1:0]    r_func;
    logic                          r_s_neg;
    logic                          r_t_neg;
    logic                          r_valid;
    logic [sau_pkg::STATUS_W-1:0]  r_status;
    logic                          r_div_start;

    logic                          accept;
    logic                          is_full;
    logic                          is_short;
    logic                          is_divop;
    logic [ADDR_W-1:0]             second_addr;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [W-1:0]                  ram_wdata;
    logic [W-1:0]                  ram_rdata;

    logic                          div_done;
    logic [W-1:0]                  div_quot;
    logic [W-1:0]                  div_rem;

    assign accept      = start && (r_state == S_IDLE);
    assign is_full     = (r_depth >= DCNT_W'(STACK_DEPTH));
    assign is_short    = (r_depth < DCNT_W'(sau_pkg::OPERANDS_NEEDED));
    assign is_divop    = (i_func == sau_pkg::FN_DIV) || (i_func == sau_pkg::FN_MOD);
    assign second_addr = ADDR_W'(r_depth - DCNT_W'(sau_pkg::OPERANDS_NEEDED));

    // The memory is written by a push in the accept cycle, or by the result
    // write-back; the two never fall in the same cycle. The read port always
    // points at the entry beneath the top.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = second_addr;
        ram_wdata = r_res;
        if (r_state == S_WRITE) begin
            ram_we = 1'b1;
        end else if (accept && (i_func == sau_pkg::FN_PUSH) && !is_full) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(r_depth);
            ram_wdata = i_push_value;
        end
    end

    sau_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (second_addr),
        .o_rdata (ram_rdata)
    );

    sau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (magnitude(ram_rdata)),
        .i_divisor  (magnitude(r_top)),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_depth  <= '0;
            r_top    <= '0;
            r_valid  <= 1'b0;
            r_status <= sau_pkg::ST_OK;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func <= i_func;
                        if (i_func == sau_pkg::FN_PUSH) begin
                            r_valid <= 1'b1;
                            if (is_full) begin
                                r_status <= sau_pkg::ST_FULL;
                            end else begin
                                r_status <= sau_pkg::ST_OK;
                                r_depth  <= r_depth + 1'b1;
                                r_top    <= i_push_value;
                            end
                        end else if (i_func > sau_pkg::FN_MOD) begin
                            // Unused codes leave everything as it is.
                            r_valid  <= 1'b1;
                            r_status <= sau_pkg::ST_OK;
                        end else if (is_short) begin
                            r_valid  <= 1'b1;
                            r_status <= sau_pkg::ST_SHORT;
                        end else if (is_divop && (r_top == '0)) begin
                            r_valid  <= 1'b1;
                            r_status <= sau_pkg::ST_DIVZERO;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    // The entry beneath the top is on the read port now.
                    r_s_neg <= ram_rdata[W-1];
                    r_t_neg <= r_top[W-1];
                    if (r_func == sau_pkg::FN_SUB) begin
                        r_res   <= ram_rdata - r_top;
                        r_state <= S_WRITE;
                    end else if (r_func == sau_pkg::FN_MUL) begin
                        r_res   <= ram_rdata * r_top;
                        r_state <= S_WRITE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        if (r_func == sau_pkg::FN_DIV) begin
                            r_res <= (r_s_neg ^ r_t_neg) ? (W'(0) - div_quot) : div_quot;
                        end else begin
                            r_res <= r_s_neg ? (W'(0) - div_rem) : div_rem;
                        end
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_depth  <= r_depth - 1'b1;
                    r_top    <= r_res;
                    r_valid  <= 1'b1;
                    r_status <= sau_pkg::ST_OK;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The divider is launched on the cycle the operands come out of memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= accept && is_divop && !is_short && (r_top != '0);
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_top_value   = r_top;
    assign o_stack_depth = sau_pkg::DEPTH_OUT_W'(r_depth);

endmodule

// ===== src/sau_ram.sv =====
module sau_ram #(
    parameter int DEPTH  = sau_pkg::STACK_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [ADDR_W-1:0]          i_waddr,
    input  logic [sau_pkg::WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]          i_raddr,
    output logic [sau_pkg::WORD_W-1:0] o_rdata
);

    logic [sau_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [sau_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sau_div.sv =====
module sau_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sau_pkg::WORD_W-1:0] i_dividend,
    input  logic [sau_pkg::WORD_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [sau_pkg::WORD_W-1:0] o_quot,
    output logic [sau_pkg::WORD_W-1:0] o_rem
);

    localparam int W     = sau_pkg::WORD_W;
    localparam int CNT_W = $clog2(W);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_quot;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dvs;

    logic [W:0] n_shift;
    logic [W:0] n_diff;

    // One restoring step: shift in the next dividend bit, try the subtraction.
    assign n_shift = {r_rem, r_quot[W-1]};
    assign n_diff  = n_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_run) begin
                if (!n_diff[W]) begin
                    r_rem <= n_diff[W-1:0];
                end else begin
                    r_rem <= n_shift[W-1:0];
                end
                r_quot <= {r_quot[W-2:0], ~n_diff[W]};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== tb/sv/testbench.sv =====
// Expected result word for one command: status, top of stack and depth after the step.
typedef struct packed {
    logic [sau_pkg::STATUS_W-1:0]    status;
    logic [sau_pkg::WORD_W-1:0]      top;
    logic [sau_pkg::DEPTH_OUT_W-1:0] depth;
} stack_result_t;

// Shadow copy of the stack. It computes what each accepted command must return and checks
// the returned words in order.
class stack_mirror;
    logic [sau_pkg::WORD_W-1:0] words [sau_pkg::STACK_DEPTH_DEF];
    int unsigned                depth;
    stack_result_t              expected_words [$];
    int unsigned                mismatches;

    function new();
        depth      = 0;
        mismatches = 0;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < 40) begin
            $display("mismatch: %s got %0h want %0h", what, got, want);
        end
        mismatches++;
    endtask

    function void note_word(logic [sau_pkg::FUNC_W-1:0] fn, logic [sau_pkg::WORD_W-1:0] value);
        logic [sau_pkg::WORD_W-1:0] tos;
        logic [sau_pkg::WORD_W-1:0] nos;
        logic [sau_pkg::WORD_W-1:0] mag_n;
        logic [sau_pkg::WORD_W-1:0] mag_d;
        logic [sau_pkg::WORD_W-1:0] res;
        stack_result_t              exp;
        exp.status = sau_pkg::ST_OK;
        if (fn == sau_pkg::FN_PUSH) begin
            if (depth >= sau_pkg::STACK_DEPTH_DEF) begin
                exp.status = sau_pkg::ST_FULL;
            end else begin
                words[depth] = value;
                depth++;
            end
        end else if (fn <= sau_pkg::FN_MOD) begin
            if (depth < sau_pkg::OPERANDS_NEEDED) begin
                exp.status = sau_pkg::ST_SHORT;
            end else begin
                tos = words[depth-1];
                nos = words[depth-2];
                if ((fn == sau_pkg::FN_DIV || fn == sau_pkg::FN_MOD) && tos == '0) begin
                    exp.status = sau_pkg::ST_DIVZERO;
                end else begin
                    // Division works on magnitudes so that the most negative word over
                    // minus one wraps instead of trapping.
                    mag_n = nos[31] ? -nos : nos;
                    mag_d = tos[31] ? -tos : tos;
                    case (fn)
                        sau_pkg::FN_SUB: res = nos - tos;
                        sau_pkg::FN_MUL: res = nos * tos;
                        sau_pkg::FN_DIV: begin
                            res = mag_n / mag_d;
                            if (nos[31] ^ tos[31]) res = -res;
                        end
                        default: begin
                            res = mag_n % mag_d;
                            if (nos[31]) res = -res;
                        end
                    endcase
                    depth--;
                    words[depth-1] = res;
                end
            end
        end
        exp.top   = (depth != 0) ? words[depth-1] : '0;
        exp.depth = depth[sau_pkg::DEPTH_OUT_W-1:0];
        expected_words.push_back(exp);
    endfunction

    task check_word(logic [sau_pkg::STATUS_W-1:0] st, logic [sau_pkg::WORD_W-1:0] top,
                    logic [sau_pkg::DEPTH_OUT_W-1:0] dep);
        stack_result_t exp;
        if (expected_words.size() == 0) begin
            report_mismatch("result word with nothing expected", {30'd0, st}, '0);
        end else begin
            exp = expected_words.pop_front();
            if (st !== exp.status) report_mismatch("status", {30'd0, st}, {30'd0, exp.status});
            if (top !== exp.top) report_mismatch("top_value", top, exp.top);
            if (dep !== exp.depth) report_mismatch("stack_depth", {25'd0, dep}, {25'd0, exp.depth});
        end
    endtask
endclass

module testbench;
    import sau_pkg::*;

    // Capacity of the stack under test; the mirror is sized from the same constant.
    localparam int STACK_SIZE = STACK_DEPTH_DEF;

    // Codes five to seven are not operations: the block must report the current state and
    // leave the stack alone.
    localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MID   = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

    localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

    localparam int RANDOM_WORDS = 1250;
    localparam int RESET_CYCLES = 11;
    // Settle time at the end, long enough to cover a divide still in flight.
    localparam int SETTLE_CYCLES = 64;
    // The limit sits well above the slowest legal run, even with every command a divide
    // and every sender gap at its longest.
    localparam int CYCLE_LIMIT = 600000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [FUNC_W-1:0]        i_func;
    logic signed [WORD_W-1:0] i_push_value;
    logic                     o_valid;
    logic [STATUS_W-1:0]      o_status;
    logic signed [WORD_W-1:0] o_top_value;
    logic [DEPTH_OUT_W-1:0]   o_stack_depth;

    stack_mirror mirror;
    int unsigned cycle_count = 0;
    // While set, the sender inserts no random gaps between commands.
    bit          no_gaps;

    stack_arithmetic_unit_top #(
        .STACK_DEPTH(STACK_SIZE)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_top_value  (o_top_value),
        .o_stack_depth(o_stack_depth)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // The receiver cannot stall, so every strobed result word is checked at the edge that
    // ends its cycle. Values read here are the ones held before this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            mirror.check_word(o_status, o_top_value, o_stack_depth);
        end
    end

    // The run limit guards against a block that hangs with busy high or drops results.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Operand values lean toward the corners of the signed range, where wrapping and the
    // sign rules of division and remainder show up.
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] val;
        case ($urandom_range(0, 11))
            0:       val = WORD_MIN;
            1:       val = WORD_MAX;
            2:       val = '0;
            3:       val = WORD_ONES;
            4:       val = 32'd1;
            5:       val = $urandom_range(0, 40) - 20;
            6:       val = $urandom_range(0, 255);
            default: val = $urandom;
        endcase
        return val;
    endfunction

    // One cycle with start low.
    task automatic idle_cycle();
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    // Present one command word and hold it until the block takes it, which happens at a
    // rising edge where busy was low. Only then is it handed to the mirror.
    task automatic send_word(logic [FUNC_W-1:0] fn, logic [WORD_W-1:0] value);
        @(negedge i_clk);
        start        <= 1'b1;
        i_func       <= fn;
        i_push_value <= value;
        do begin
            @(posedge i_clk);
        end while (busy);
        mirror.note_word(fn, value);
    endtask

    // Random sender gaps: each cycle before a command is idle with a chance of one in five.
    task automatic issue(logic [FUNC_W-1:0] fn, logic [WORD_W-1:0] value);
        if (!no_gaps) begin
            while ($urandom_range(0, 99) < 20) idle_cycle();
        end
        send_word(fn, value);
    endtask

    // Stop sending until every outstanding result word has come back.
    task automatic wait_until_drained();
        idle_cycle();
        while (mirror.expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic issue_random_op();
        logic [FUNC_W-1:0] fn;
        fn = FUNC_W'($urandom_range(FN_SUB, FN_MOD));
        issue(fn, $urandom);
    endtask

    // Hand-picked sequence: errors on an empty and a one-entry stack, signed wrapping in
    // sub and mul, the most negative word over minus one, zero divisors, the sign of the
    // remainder and the spare codes.
    task automatic run_directed();
        issue(FN_SUB, $urandom);
        issue(FN_DIV, $urandom);
        issue(FN_PUSH, WORD_MAX);
        issue(FN_MOD, $urandom);
        issue(FN_MUL, $urandom);
        issue(FN_PUSH, WORD_ONES);
        issue(FN_SUB, $urandom);       // MAX minus minus one wraps to MIN
        issue(FN_PUSH, WORD_ONES);
        issue(FN_DIV, $urandom);       // MIN over minus one stays MIN
        issue(FN_PUSH, WORD_ONES);
        issue(FN_MOD, $urandom);       // and its remainder is zero
        issue(FN_PUSH, '0);
        issue(FN_DIV, $urandom);       // zero divisor, stack unchanged
        issue(FN_MOD, $urandom);
        issue(FN_MUL, $urandom);
        issue(FN_PUSH, WORD_MAX);
        issue(FN_PUSH, WORD_MAX);
        issue(FN_MUL, $urandom);       // product wraps to one
        issue(FN_PUSH, -32'sd7);
        issue(FN_PUSH, 32'd2);
        issue(FN_MOD, $urandom);       // remainder takes the sign of the dividend
        issue(FN_SPARE_FIRST, WORD_ONES);
        issue(FN_SPARE_MID, '0);
        issue(FN_SPARE_LAST, $urandom);
        issue(FN_PUSH, WORD_MIN);
    endtask

    // Mostly well-formed work on a stack of a few entries, with episodes that fill the
    // stack past full and drain it below two entries, plus spare codes as noise.
    task automatic run_random();
        int unsigned done;
        int unsigned extra;
        done = 0;
        while (done < RANDOM_WORDS) begin
            no_gaps = (done >= 500 && done < 750);
            if (done == 0 || $urandom_range(0, 199) == 0) begin
                while (mirror.depth < STACK_SIZE) begin
                    issue(FN_PUSH, pick_word());
                    done++;
                end
                extra = $urandom_range(1, 3);
                repeat (extra) begin
                    issue(FN_PUSH, pick_word());
                    done++;
                end
            end else if ($urandom_range(0, 149) == 0) begin
                while (mirror.depth >= OPERANDS_NEEDED) begin
                    issue_random_op();
                    done++;
                end
                extra = $urandom_range(1, 2);
                repeat (extra) begin
                    issue_random_op();
                    done++;
                end
            end else if ($urandom_range(0, 199) == 0) begin
                wait_until_drained();
            end else if ($urandom_range(0, 99) < 8) begin
                issue(FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)), $urandom);
            end else begin
                if (mirror.depth < OPERANDS_NEEDED ||
                    (mirror.depth < 6 && $urandom_range(0, 1) == 0) ||
                    $urandom_range(0, 99) < 30) begin
                    issue(FN_PUSH, pick_word());
                end else begin
                    issue_random_op();
                end
                done++;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        mirror       = new();
        no_gaps      = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_func       = FN_PUSH;
        i_push_value = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        // The sender holds off once here until the block has answered everything.
        wait_until_drained();
        run_random();

        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mirror.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/sau_pkg.sv
src/sau_ram.sv
src/sau_div.sv
src/stack_arithmetic_unit_top.sv
tb/sv/testbench.sv
